// File: hdl/acu_pkg.sv
// acu_pkg: opcodes, widths and shared types of the accumulator execute unit
// used by the channel interfaces and all modules of the block; no dependencies
package acu_pkg;

  localparam int CMD_W  = 4;
  localparam int OPND_W = 16;
  localparam int DATA_W = 8;

  // instruction codes
  localparam logic [CMD_W-1:0] OP_ADDX = 4'd0;
  localparam logic [CMD_W-1:0] OP_ADDA = 4'd1;
  localparam logic [CMD_W-1:0] OP_ADDB = 4'd2;
  localparam logic [CMD_W-1:0] OP_MOVA = 4'd3;
  localparam logic [CMD_W-1:0] OP_MOVB = 4'd4;
  localparam logic [CMD_W-1:0] OP_MOAB = 4'd5;
  localparam logic [CMD_W-1:0] OP_MOBA = 4'd6;
  localparam logic [CMD_W-1:0] OP_LDA  = 4'd7;
  localparam logic [CMD_W-1:0] OP_STA  = 4'd8;
  localparam logic [CMD_W-1:0] OP_JMP  = 4'd9;
  localparam logic [CMD_W-1:0] OP_JMZ  = 4'd10;
  localparam logic [CMD_W-1:0] OP_JNZ  = 4'd11;
  localparam logic [CMD_W-1:0] OP_JCS  = 4'd12;
  localparam logic [CMD_W-1:0] OP_PTA  = 4'd13;
  localparam logic [CMD_W-1:0] OP_AAX  = 4'd14;
  localparam logic [CMD_W-1:0] OP_MOVX = 4'd15;

  // architectural registers and flags
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] x;
    logic              carry;
    logic              zero;
  } arch_t;

  // one result word
  typedef struct packed {
    logic              status;
    logic              branch_taken;
    logic [OPND_W-1:0] branch_target;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              carry;
    logic              zero;
  } result_t;

  // decoded instruction handed from the fetch stage to the execute logic
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [OPND_W-1:0] operand;
    logic              in_range;
    logic [DATA_W-1:0] mem_value;
  } issue_t;

endpackage

// File: hdl/acu_in_if.sv
// acu_in_if: instruction channel, valid/ready handshake with cmd and operand
// depends on acu_pkg for field widths
interface acu_in_if;
  logic                         valid;
  logic                         ready;
  logic [acu_pkg::CMD_W-1:0]    cmd;
  logic [acu_pkg::OPND_W-1:0]   operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink   (input valid, input cmd, input operand, output ready);
endinterface

// File: hdl/acu_out_if.sv
// acu_out_if: result channel, valid/ready handshake with the result fields
// depends on acu_pkg for field widths
interface acu_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic                         branch_taken;
  logic [acu_pkg::OPND_W-1:0]   branch_target;
  logic                         print_valid;
  logic [acu_pkg::DATA_W-1:0]   print_value;
  logic                         carry;
  logic                         zero;

  modport source (output valid, output status, output branch_taken, output branch_target,
                  output print_valid, output print_value, output carry, output zero,
                  input ready);
  modport sink   (input valid, input status, input branch_taken, input branch_target,
                  input print_valid, input print_value, input carry, input zero,
                  output ready);
endinterface

// File: hdl/acu_fetch.sv
// acu_fetch: input register, data memory with clearing pass and store bypass
// depends on acu_pkg and acu_in_if
module acu_fetch #(
  parameter int MEM_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  acu_in_if.sink                      instr,
  input  logic                        fire,
  input  logic                        store_en,
  input  logic [acu_pkg::DATA_W-1:0]  store_data,
  output logic                        issue_valid,
  output acu_pkg::issue_t             issue
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [acu_pkg::DATA_W-1:0] mem [MEM_DEPTH];

  logic                         clearing;
  logic [AW-1:0]                clr_addr;
  logic                         accept;
  logic                         write_en;
  logic [AW-1:0]                rd_idx;
  logic [AW-1:0]                wr_idx;
  logic                         s1_valid;
  logic [acu_pkg::CMD_W-1:0]    s1_cmd;
  logic [acu_pkg::OPND_W-1:0]   s1_operand;
  logic                         s1_in_range;
  logic [acu_pkg::DATA_W-1:0]   rdata;
  logic                         fwd_hit;
  logic [acu_pkg::DATA_W-1:0]   fwd_data;

  // handshake: free slot or slot draining this cycle, and memory cleared
  assign instr.ready = !clearing && (!s1_valid || fire);
  assign accept      = instr.valid && instr.ready;
  assign rd_idx      = instr.operand[AW-1:0];
  assign wr_idx      = s1_operand[AW-1:0];
  assign write_en    = fire && store_en;

  // clearing pass after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // data memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (write_en) begin
      mem[wr_idx] <= store_data;
    end
    if (accept) begin
      rdata <= mem[rd_idx];
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  // stage payload and bypass of a store landing at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= instr.cmd;
      s1_operand  <= instr.operand;
      s1_in_range <= ({1'b0, instr.operand} < (acu_pkg::OPND_W + 1)'(MEM_DEPTH));
      fwd_hit     <= write_en && (wr_idx == rd_idx);
      fwd_data    <= store_data;
    end
  end

  assign issue_valid       = s1_valid;
  assign issue.cmd         = s1_cmd;
  assign issue.operand     = s1_operand;
  assign issue.in_range    = s1_in_range;
  assign issue.mem_value   = fwd_hit ? fwd_data : rdata;

endmodule

// File: hdl/acu_exec.sv
// acu_exec: combinational execute of one instruction against the register state
// depends on acu_pkg
module acu_exec (
  input  acu_pkg::issue_t             issue,
  input  acu_pkg::arch_t              state,
  output acu_pkg::arch_t              state_next,
  output acu_pkg::result_t            res,
  output logic                        store_en
);

  logic                         needs_addr;
  logic                         addr_fault;
  logic [acu_pkg::DATA_W-1:0]   imm;
  logic [acu_pkg::DATA_W-1:0]   add_lhs;
  logic [acu_pkg::DATA_W-1:0]   add_rhs;
  logic [acu_pkg::DATA_W:0]     sum;
  logic [acu_pkg::DATA_W-1:0]   sum_lo;
  logic                         sum_zero;
  logic                         taken;

  assign imm = issue.operand[acu_pkg::DATA_W-1:0];

  // memory-addressing and jump instructions check the operand range
  always_comb begin
    case (issue.cmd)
      acu_pkg::OP_LDA, acu_pkg::OP_STA, acu_pkg::OP_JMP, acu_pkg::OP_JMZ,
      acu_pkg::OP_JNZ, acu_pkg::OP_JCS, acu_pkg::OP_AAX, acu_pkg::OP_MOVX:
        needs_addr = 1'b1;
      default:
        needs_addr = 1'b0;
    endcase
  end
  assign addr_fault = needs_addr && !issue.in_range;

  // shared adder operands
  always_comb begin
    case (issue.cmd)
      acu_pkg::OP_ADDA: begin
        add_lhs = state.a;
        add_rhs = imm;
      end
      acu_pkg::OP_ADDB: begin
        add_lhs = state.b;
        add_rhs = imm;
      end
      acu_pkg::OP_AAX: begin
        add_lhs = state.x;
        add_rhs = issue.mem_value;
      end
      default: begin
        add_lhs = state.x;
        add_rhs = imm;
      end
    endcase
  end

  assign sum      = {1'b0, add_lhs} + {1'b0, add_rhs};
  assign sum_lo   = sum[acu_pkg::DATA_W-1:0];
  assign sum_zero = (sum_lo == '0);

  // register update and branch decision
  always_comb begin
    state_next = state;
    taken      = 1'b0;
    store_en   = 1'b0;
    if (!addr_fault) begin
      case (issue.cmd)
        acu_pkg::OP_ADDX: begin
          state_next.x     = sum_lo;
          state_next.carry = sum[acu_pkg::DATA_W];
          state_next.zero  = sum_zero;
        end
        acu_pkg::OP_ADDA: begin
          state_next.a     = sum_lo;
          state_next.carry = sum[acu_pkg::DATA_W];
          state_next.zero  = sum_zero;
        end
        acu_pkg::OP_ADDB: begin
          state_next.b     = sum_lo;
          state_next.carry = sum[acu_pkg::DATA_W];
          state_next.zero  = sum_zero;
        end
        acu_pkg::OP_MOVA: state_next.a = imm;
        acu_pkg::OP_MOVB: state_next.b = imm;
        acu_pkg::OP_MOAB: state_next.b = state.a;
        acu_pkg::OP_MOBA: state_next.a = state.b;
        acu_pkg::OP_LDA:  state_next.a = issue.mem_value;
        acu_pkg::OP_STA:  store_en = 1'b1;
        acu_pkg::OP_JMP:  taken = 1'b1;
        acu_pkg::OP_JMZ:  taken = state.zero;
        acu_pkg::OP_JNZ:  taken = !state.zero;
        acu_pkg::OP_JCS:  taken = state.carry;
        acu_pkg::OP_PTA:  ;
        acu_pkg::OP_AAX: begin
          state_next.x     = sum_lo;
          state_next.carry = sum[acu_pkg::DATA_W];
          state_next.zero  = sum_zero;
        end
        acu_pkg::OP_MOVX: state_next.x = issue.mem_value;
        default: ;
      endcase
    end
  end

  // result word
  always_comb begin
    res.status        = addr_fault;
    res.branch_taken  = taken;
    res.branch_target = taken ? issue.operand : '0;
    res.print_valid   = (issue.cmd == acu_pkg::OP_PTA);
    res.print_value   = (issue.cmd == acu_pkg::OP_PTA) ? state.a : '0;
    res.carry         = state_next.carry;
    res.zero          = state_next.zero;
  end

endmodule

// File: hdl/accumulator_cpu_execute_unit_core.sv
// accumulator_cpu_execute_unit_core: top level of the 8-bit accumulator execute unit
// depends on acu_pkg, acu_in_if, acu_out_if, acu_fetch and acu_exec
//
// Usage:
//   instr carries one instruction word (cmd, operand) per handshake; result
//   returns one word per instruction: status, branch decision and target,
//   print request and value, and the carry and zero flags after execution.
//   The instruction handshake loads the input register and the data memory
//   read; execute then writes the result register, which drives result.valid.
//   Throughput is one instruction per cycle while result.ready stays high.
//   A store feeding a load or add on the next instruction is bypassed
//   around the memory read port, so back-to-back words need no bubbles.
//   After reset, registers and flags are zero and the data memory is swept
//   to zero, one entry per cycle, with instr.ready low until the sweep ends.
//   When result.ready is low the result register holds its word, one more
//   instruction may be taken into the input register, and instr.ready then
//   drops until the result register drains.
module accumulator_cpu_execute_unit_core #(
  parameter int MEM_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  acu_in_if.sink      instr,
  acu_out_if.source   result
);

  logic                       issue_valid;
  acu_pkg::issue_t            issue;
  acu_pkg::arch_t             state;
  acu_pkg::arch_t             state_next;
  acu_pkg::result_t           res;
  acu_pkg::result_t           res_q;
  logic                       store_en;
  logic                       fire;
  logic                       out_valid;

  // execute when an instruction waits and the result register can take it
  assign fire = issue_valid && (!out_valid || result.ready);

  acu_fetch #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_fetch (
    .clk         (clk),
    .rst         (rst),
    .instr       (instr),
    .fire        (fire),
    .store_en    (store_en),
    .store_data  (state.a),
    .issue_valid (issue_valid),
    .issue       (issue)
  );

  acu_exec u_exec (
    .issue      (issue),
    .state      (state),
    .state_next (state_next),
    .res        (res),
    .store_en   (store_en)
  );

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = res_q.status;
  assign result.branch_taken  = res_q.branch_taken;
  assign result.branch_target = res_q.branch_target;
  assign result.print_valid   = res_q.print_valid;
  assign result.print_value   = res_q.print_value;
  assign result.carry         = res_q.carry;
  assign result.zero          = res_q.zero;

endmodule

// File: dv/tb.sv
// tb: self-checking bench for accumulator_cpu_execute_unit_core
// depends on acu_pkg, acu_in_if, acu_out_if and the core; an in-bench predictor of
// registers, flags and data memory checks every result word against the instruction stream
module tb;

  localparam int MEM_DEPTH = 256;
  localparam int HALF_PERIOD = 6;
  localparam int LIMIT_CYCLES = 300000;
  localparam int CMD_W = acu_pkg::CMD_W;
  localparam int OPND_W = acu_pkg::OPND_W;
  localparam int DATA_W = acu_pkg::DATA_W;

  logic clk = 1'b0;
  logic rst;

  acu_in_if  instr_ch ();
  acu_out_if result_ch ();

  accumulator_cpu_execute_unit_core #(
    .MEM_DEPTH(MEM_DEPTH)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .instr (instr_ch),
    .result(result_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // predicted machine state
  logic [DATA_W-1:0] acc_a;
  logic [DATA_W-1:0] acc_b;
  logic [DATA_W-1:0] idx_x;
  logic              carry_f;
  logic              zero_f;
  logic [DATA_W-1:0] data_mem [MEM_DEPTH];

  acu_pkg::result_t pending_results [$];

  int mismatches = 0;
  int words_checked = 0;
  int op_count [16];
  int branches_taken = 0;
  int prints_seen = 0;
  int addr_errors = 0;

  int tx_idle_max = 9;
  int rx_idle_max = 9;
  int hold_cycles = 0;

  function automatic logic is_addr_op(input logic [CMD_W-1:0] cmd);
    return (cmd >= acu_pkg::OP_LDA && cmd <= acu_pkg::OP_JCS) || cmd == acu_pkg::OP_AAX ||
           cmd == acu_pkg::OP_MOVX;
  endfunction

  // 8-bit add, flags come from the sum of this add
  function automatic logic [DATA_W-1:0] add_flags(input logic [DATA_W-1:0] lhs,
                                                  input logic [DATA_W-1:0] rhs);
    logic [DATA_W:0] sum;
    sum = {1'b0, lhs} + {1'b0, rhs};
    carry_f = sum[DATA_W];
    zero_f = (sum[DATA_W-1:0] == '0);
    return sum[DATA_W-1:0];
  endfunction

  // executes one instruction on the predicted state and returns its result word
  function automatic acu_pkg::result_t exec_instr(input logic [CMD_W-1:0] cmd,
                                                  input logic [OPND_W-1:0] opnd);
    acu_pkg::result_t  r;
    logic              in_range;
    logic [DATA_W-1:0] imm;
    int                addr;
    r = '0;
    imm = opnd[DATA_W-1:0];
    in_range = (int'(opnd) < MEM_DEPTH);
    addr = in_range ? int'(opnd) : 0;
    if (is_addr_op(cmd) && !in_range) begin
      r.status = 1'b1;
    end else begin
      case (cmd)
        acu_pkg::OP_ADDX: idx_x = add_flags(idx_x, imm);
        acu_pkg::OP_ADDA: acc_a = add_flags(acc_a, imm);
        acu_pkg::OP_ADDB: acc_b = add_flags(acc_b, imm);
        acu_pkg::OP_MOVA: acc_a = imm;
        acu_pkg::OP_MOVB: acc_b = imm;
        acu_pkg::OP_MOAB: acc_b = acc_a;
        acu_pkg::OP_MOBA: acc_a = acc_b;
        acu_pkg::OP_LDA:  acc_a = data_mem[addr];
        acu_pkg::OP_STA:  data_mem[addr] = acc_a;
        acu_pkg::OP_JMP:  r.branch_taken = 1'b1;
        acu_pkg::OP_JMZ:  r.branch_taken = zero_f;
        acu_pkg::OP_JNZ:  r.branch_taken = !zero_f;
        acu_pkg::OP_JCS:  r.branch_taken = carry_f;
        acu_pkg::OP_PTA: begin
          r.print_valid = 1'b1;
          r.print_value = acc_a;
        end
        acu_pkg::OP_AAX:  idx_x = add_flags(idx_x, data_mem[addr]);
        default: idx_x = data_mem[addr];
      endcase
      if (r.branch_taken) r.branch_target = opnd;
    end
    r.carry = carry_f;
    r.zero = zero_f;
    return r;
  endfunction

  // predict on every accepted instruction word
  always @(posedge clk) begin
    if (rst) begin
      acc_a = '0;
      acc_b = '0;
      idx_x = '0;
      carry_f = 1'b0;
      zero_f = 1'b0;
      for (int i = 0; i < MEM_DEPTH; i++) data_mem[i] = '0;
    end else if (instr_ch.valid && instr_ch.ready) begin
      pending_results.push_back(exec_instr(instr_ch.cmd, instr_ch.operand));
      op_count[instr_ch.cmd]++;
    end
  end

  task automatic check_field(input string field, input logic [OPND_W-1:0] expv,
                             input logic [OPND_W-1:0] actv);
    if (expv !== actv) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, expv, actv);
    end
  endtask

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    acu_pkg::result_t exp_r;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with no instruction pending, expected none, actual 0x%0h",
                 $time, result_ch.branch_target);
      end else begin
        exp_r = pending_results.pop_front();
        words_checked++;
        if (exp_r.status) addr_errors++;
        if (exp_r.branch_taken) branches_taken++;
        if (exp_r.print_valid) prints_seen++;
        check_field("status", exp_r.status, result_ch.status);
        check_field("branch_taken", exp_r.branch_taken, result_ch.branch_taken);
        check_field("branch_target", exp_r.branch_target, result_ch.branch_target);
        check_field("print_valid", exp_r.print_valid, result_ch.print_valid);
        check_field("print_value", exp_r.print_value, result_ch.print_value);
        check_field("carry", exp_r.carry, result_ch.carry);
        check_field("zero", exp_r.zero, result_ch.zero);
      end
    end
  end

  // result side: random stall per word, long hold-off on request
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    forever begin
      if (hold_cycles > 0) stall = hold_cycles;
      else stall = $urandom_range(0, rx_idle_max);
      hold_cycles = 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // offer one instruction word after a random gap and wait for its handshake
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [OPND_W-1:0] opnd);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.cmd <= cmd;
    instr_ch.operand <= opnd;
    do @(posedge clk); while (!instr_ch.ready);
  endtask

  // address biased to edges, a small hot pool and just past the memory, else in memory or any value
  function automatic logic [OPND_W-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return OPND_W'($urandom_range(0, 7));
      4, 5, 6:    return OPND_W'($urandom_range(0, MEM_DEPTH - 1));
      7:          return $urandom_range(0, 1) ? OPND_W'(MEM_DEPTH - 1) : '0;
      8:          return OPND_W'(MEM_DEPTH + $urandom_range(0, 3));
      default:    return OPND_W'($urandom);
    endcase
  endfunction

  function automatic logic [OPND_W-1:0] pick_operand(input logic [CMD_W-1:0] cmd);
    if (is_addr_op(cmd)) return pick_addr();
    return OPND_W'($urandom);
  endfunction

  // immediate adds and moves, carry and zero, register transfers and print
  task automatic test_immediate_ops();
    send_word(acu_pkg::OP_MOVA, 16'hAB80);
    send_word(acu_pkg::OP_ADDA, 16'h0080);
    send_word(acu_pkg::OP_PTA,  16'hFFFF);
    send_word(acu_pkg::OP_JCS,  16'h00FF);
    send_word(acu_pkg::OP_JMZ,  16'h0010);
    send_word(acu_pkg::OP_ADDB, 16'hFFFF);
    send_word(acu_pkg::OP_JNZ,  16'h0001);
    send_word(acu_pkg::OP_ADDX, 16'h01FF);
    send_word(acu_pkg::OP_ADDX, 16'h0001);
    send_word(acu_pkg::OP_MOVB, 16'h0055);
    send_word(acu_pkg::OP_MOBA, 16'h0000);
    send_word(acu_pkg::OP_MOAB, 16'h0000);
    send_word(acu_pkg::OP_PTA,  16'h0000);
  endtask

  // loads, stores and memory adds at both ends of memory and out of range
  task automatic test_memory_ops();
    send_word(acu_pkg::OP_STA,  16'(MEM_DEPTH - 1));
    send_word(acu_pkg::OP_LDA,  16'h0000);
    send_word(acu_pkg::OP_LDA,  16'(MEM_DEPTH - 1));
    send_word(acu_pkg::OP_STA,  16'(MEM_DEPTH));
    send_word(acu_pkg::OP_MOVX, 16'(MEM_DEPTH - 1));
    send_word(acu_pkg::OP_AAX,  16'(MEM_DEPTH - 1));
    send_word(acu_pkg::OP_AAX,  16'hFFFF);
    send_word(acu_pkg::OP_LDA,  16'h8000);
  endtask

  // unconditional and conditional jumps, taken, not taken and out of range
  task automatic test_jumps();
    send_word(acu_pkg::OP_JMP, 16'(MEM_DEPTH - 1));
    send_word(acu_pkg::OP_JMP, 16'(MEM_DEPTH));
    send_word(acu_pkg::OP_JMZ, 16'hFFFF);
    send_word(acu_pkg::OP_JMZ, 16'h0040);
    send_word(acu_pkg::OP_JCS, 16'h0040);
  endtask

  // long result hold-off while instructions keep coming back to back
  task automatic test_full_stall();
    int saved_tx;
    saved_tx = tx_idle_max;
    tx_idle_max = 0;
    hold_cycles = 80;
    for (int i = 0; i < 20; i++) begin
      logic [CMD_W-1:0] cmd;
      cmd = CMD_W'($urandom_range(0, 15));
      send_word(cmd, pick_operand(cmd));
    end
    tx_idle_max = saved_tx;
  endtask

  // random programs: store then use, add then branch, single ops and noise
  task automatic test_random_program(input int n_words);
    int sent;
    int next_mode;
    logic [CMD_W-1:0]  cmd;
    logic [OPND_W-1:0] addr;
    sent = 0;
    next_mode = 0;
    while (sent < n_words) begin
      if (sent >= next_mode) begin
        next_mode += 200;
        case ($urandom_range(0, 3))
          0: begin tx_idle_max = 0; rx_idle_max = 0; end
          1: begin tx_idle_max = 9; rx_idle_max = 0; end
          2: begin tx_idle_max = 0; rx_idle_max = 9; end
          default: begin tx_idle_max = 9; rx_idle_max = 9; end
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          addr = pick_addr();
          send_word(acu_pkg::OP_STA, addr);
          case ($urandom_range(0, 2))
            0: cmd = acu_pkg::OP_LDA;
            1: cmd = acu_pkg::OP_AAX;
            default: cmd = acu_pkg::OP_MOVX;
          endcase
          send_word(cmd, $urandom_range(0, 3) == 0 ? pick_addr() : addr);
          sent += 2;
        end
        3, 4, 5: begin
          cmd = CMD_W'($urandom_range(0, 2));
          send_word(cmd, OPND_W'($urandom));
          cmd = CMD_W'($urandom_range(acu_pkg::OP_JMZ, acu_pkg::OP_JCS));
          send_word(cmd, pick_addr());
          sent += 2;
        end
        6, 7, 8: begin
          cmd = CMD_W'($urandom_range(0, 15));
          send_word(cmd, pick_operand(cmd));
          sent += 1;
        end
        default: begin
          cmd = CMD_W'($urandom_range(0, 15));
          send_word(cmd, OPND_W'($urandom));
          sent += 1;
        end
      endcase
    end
    tx_idle_max = 9;
    rx_idle_max = 9;
  endtask

  initial begin
    int opcodes_hit;
    rst <= 1'b1;
    instr_ch.valid <= 1'b0;
    instr_ch.cmd <= acu_pkg::OP_ADDX;
    instr_ch.operand <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_immediate_ops();
    test_memory_ops();
    test_jumps();
    test_full_stall();
    test_random_program(1600);

    instr_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    opcodes_hit = 0;
    foreach (op_count[i]) if (op_count[i] > 0) opcodes_hit++;
    $display("tb: %0d result words checked, %0d of 16 opcodes exercised", words_checked,
             opcodes_hit);
    $display("tb: %0d branches taken, %0d prints, %0d address errors, %0d mismatches",
             branches_taken, prints_seen, addr_errors, mismatches);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // run-time limit
  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("tb: timeout with %0d results outstanding", pending_results.size());
    $display("tb: errors");
    $finish;
  end

endmodule
